### src/ledfx_pkg.sv
// Shared types, constants and helper functions of the LED strip effect generator.
package ledfx_pkg;

    // Strip geometry.
    localparam int MAX_STRIP_PIXELS = 64;
    localparam int PIX_W            = $clog2(MAX_STRIP_PIXELS);
    localparam int CNT_W            = $clog2(MAX_STRIP_PIXELS + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED = 3'd5;

    // Effect mode codes.
    localparam logic [2:0] MODE_STATIC  = 3'd0;
    localparam logic [2:0] MODE_RAINBOW = 3'd1;
    localparam logic [2:0] MODE_BLINK   = 3'd2;
    localparam logic [2:0] MODE_PULSE   = 3'd3;
    localparam logic [2:0] MODE_CHASE   = 3'd4;
    localparam logic [2:0] MODE_SPARKLE = 3'd5;

    // Timing constants in milliseconds.
    localparam logic [15:0] RAINBOW_PERIOD = 16'd50;
    localparam logic [15:0] PULSE_PERIOD   = 16'd25;
    localparam logic [15:0] MIN_PERIOD     = 16'd20;
    localparam logic [15:0] DEFAULT_SPEED  = 16'd500;
    localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

    // Hue span spread over the strip.
    localparam logic [15:0] HUE_SPAN = 16'd256;

    // Reciprocal for speed / 21: floor(x * 99865 / 2^21) is exact for 16-bit x.
    localparam logic [16:0] RECIP_21       = 17'd99865;
    localparam int          RECIP_21_SHIFT = 21;
    localparam int          STEP_PROD_W    = 33;

    // Sparkle pseudo-random generator.
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Serial divider.
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic {
        DIV_PERIOD = 1'b0,
        DIV_FRAME  = 1'b1
    } div_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     tick_inc;
        logic     div_start;
        div_sel_t div_sel;
        logic     fire;
        logic     div_capture;
        logic     scale_load;
        logic     emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] mode;
        logic       fire_ok;
        logic       div_done;
        logic       slot_free;
        logic       last;
    } status_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Six-segment colour wheel; segments are 43 hue steps wide, the last one 41.
    function automatic rgb_t hue_wheel(input logic [7:0] hue);
        logic [2:0] seg;
        logic [7:0] base;
        logic [7:0] rem;
        logic [7:0] ramp;
        rgb_t       c;
        if (hue < 8'd43) begin
            seg  = 3'd0;
            base = 8'd0;
        end else if (hue < 8'd86) begin
            seg  = 3'd1;
            base = 8'd43;
        end else if (hue < 8'd129) begin
            seg  = 3'd2;
            base = 8'd86;
        end else if (hue < 8'd172) begin
            seg  = 3'd3;
            base = 8'd129;
        end else if (hue < 8'd215) begin
            seg  = 3'd4;
            base = 8'd172;
        end else begin
            seg  = 3'd5;
            base = 8'd215;
        end
        rem  = hue - base;
        ramp = {rem[5:0], 2'b00} + {rem[6:0], 1'b0};
        case (seg)
            3'd0: c = '{r: 8'd255, g: ramp,   b: 8'd0};
            3'd1: c = '{r: ~ramp,  g: 8'd255, b: 8'd0};
            3'd2: c = '{r: 8'd0,   g: 8'd255, b: ramp};
            3'd3: c = '{r: 8'd0,   g: ~ramp,  b: 8'd255};
            3'd4: c = '{r: ramp,   g: 8'd0,   b: 8'd255};
            default: c = '{r: 8'd255, g: 8'd0, b: ~ramp};
        endcase
        return c;
    endfunction

    // One step of the right-shifting Galois LFSR.
    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        return s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
    endfunction

    // Exact floor(p / 255) for a product of two 8-bit values.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [15:0] t;
        t = p + {8'd0, p[15:8]} + 16'd1;
        return t[15:8];
    endfunction

endpackage

### src/led_strip_effect_generator_core.sv
// Top level of the LED strip effect generator: controller plus datapath.
//
//  Channel   Handshake                Payload
//  -------   ----------------------   -------------------------------------------
//  input     in_valid / in_ready      tick
//  output    out_valid / out_ready    pixel_index, red, green, blue, last_pixel
//  config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A tick that does not end a period only passes the period check, in chase mode after the
// speed / pixel_count division done by the shared serial divider (one bit per cycle).
// A firing tick then emits one pixel per cycle while the output is free; pulse first
// loads the colour scaling, and rainbow, chase and sparkle first wait for the divider.
// Reset is asynchronous and active low; configuration, effect state, control state and
// the output valid flag take their defaults at once and no clearing pass follows.
// A stalled output holds the pixel sequence; the last pixel of a frame may wait in
// the output register while the next item is taken.
module led_strip_effect_generator_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             tick,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ledfx_pkg::PIX_W-1:0]      pixel_index,
    output logic [7:0]                       red,
    output logic [7:0]                       green,
    output logic [7:0]                       blue,
    output logic                             last_pixel,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ledfx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ledfx_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ledfx_pkg::*;

    cmd_t    cmd;
    status_t st;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    ledfx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .tick     (tick),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    ledfx_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_pixel  (last_pixel)
    );

endmodule

### src/ledfx_div.sv
// Restoring serial divider, one quotient bit per cycle.
module ledfx_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [15:0]                dividend,
    input  logic [ledfx_pkg::CNT_W-1:0] divisor,
    output logic [15:0]                quotient,
    output logic [ledfx_pkg::CNT_W-1:0] remainder,
    output logic                       done
);
    import ledfx_pkg::*;

    logic [15:0]          quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       diff;
    logic                 ge;

    // Shift in the next dividend bit and try a subtraction.
    always_comb
    begin
        trial = {rem_reg, quo_reg[15]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[14:0], ge};
            rem_reg <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

    // A start always sets the unit busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider not busy after start");

    // Completion is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

    // Completion never overlaps an iteration.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

### src/ledfx_dp.sv
// Datapath: configuration registers, effect state, pixel generation and output register.
module ledfx_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [ledfx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ledfx_pkg::CFG_DATA_W-1:0] cfg_data,
    input  ledfx_pkg::cmd_t                cmd,
    output ledfx_pkg::status_t             st,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ledfx_pkg::PIX_W-1:0]    pixel_index,
    output logic [7:0]                     red,
    output logic [7:0]                     green,
    output logic [7:0]                     blue,
    output logic                           last_pixel
);
    import ledfx_pkg::*;

    // Configuration.
    logic [2:0]       mode_reg;
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;
    logic [7:0]       blue_reg;
    logic [15:0]      speed_reg;

    // Effect state.
    logic [15:0]      elapsed_reg;
    logic [7:0]       hue_reg;
    logic [8:0]       phase_reg;
    logic             blink_reg;
    logic [PIX_W-1:0] chase_reg;
    logic [15:0]      rand_reg;

    // Frame working registers.
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] lit_reg;
    logic [7:0]       step_a_reg;
    logic [CNT_W-1:0] step_b_reg;
    logic [7:0]       acc_q_reg;
    logic [CNT_W-1:0] acc_r_reg;
    logic [STEP_PROD_W-1:0] step_prod_reg;
    logic [15:0]      scale_r_reg;
    logic [15:0]      scale_g_reg;
    logic [15:0]      scale_b_reg;

    // Output register.
    logic             out_valid_reg;
    logic [PIX_W-1:0] pixel_index_reg;
    logic [7:0]       red_reg_o;
    logic [7:0]       green_reg_o;
    logic [7:0]       blue_reg_o;
    logic             last_pixel_reg;

    logic             mode_wr;
    logic [CNT_W-1:0] count_wr;
    logic [15:0]      speed_wr;

    logic [15:0]      div_dividend;
    logic [15:0]      div_quo;
    logic [CNT_W-1:0] div_rem;
    logic             div_done;

    logic [15:0]      period;
    logic             active;
    logic [11:0]      step_raw;
    logic [8:0]       step9;
    logic [7:0]       bright;
    logic [PIX_W:0]   chase_inc;
    logic [CNT_W:0]   acc_sum;
    logic             acc_wrap;
    rgb_t             pix_color;
    rgb_t             eff_color;
    logic             is_last;

    assign mode_wr = cfg_valid && (cfg_index == REG_MODE);

    // Clamp a written pixel count into 1..MAX_STRIP_PIXELS.
    always_comb
    begin
        if (cfg_data[CNT_W-1:0] == '0)
            count_wr = CNT_W'(1);
        else if (cfg_data[CNT_W-1:0] > CNT_W'(MAX_STRIP_PIXELS))
            count_wr = CNT_W'(MAX_STRIP_PIXELS);
        else
            count_wr = cfg_data[CNT_W-1:0];
        speed_wr = (cfg_data == 16'd0) ? DEFAULT_SPEED : cfg_data;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_STATIC;
            count_reg <= CNT_W'(MAX_STRIP_PIXELS);
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
            speed_reg <= DEFAULT_SPEED;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[2:0];
                REG_COUNT: count_reg <= count_wr;
                REG_RED:   red_reg   <= cfg_data[7:0];
                REG_GREEN: green_reg <= cfg_data[7:0];
                REG_BLUE:  blue_reg  <= cfg_data[7:0];
                REG_SPEED: speed_reg <= speed_wr;
                default:   ;
            endcase
        end
    end

    // Shared divider: period of the chase effect, hue step and lit pixel.
    always_comb
    begin
        if (cmd.div_sel == DIV_PERIOD)
            div_dividend = speed_reg;
        else if (mode_reg == MODE_RAINBOW)
            div_dividend = HUE_SPAN;
        else if (mode_reg == MODE_SPARKLE)
            div_dividend = lfsr_step(rand_reg);
        else
            div_dividend = {{(16 - PIX_W){1'b0}}, chase_reg};
    end

    ledfx_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (count_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Effect period and firing decision.
    always_comb
    begin
        active = 1'b1;
        period = RAINBOW_PERIOD;
        case (mode_reg)
            MODE_RAINBOW: period = RAINBOW_PERIOD;
            MODE_BLINK:   period = speed_reg;
            MODE_PULSE:   period = PULSE_PERIOD;
            MODE_CHASE:   period = (div_quo < MIN_PERIOD) ? MIN_PERIOD : div_quo;
            MODE_SPARKLE: period = ((speed_reg >> 3) < MIN_PERIOD) ? MIN_PERIOD
                                                                   : (speed_reg >> 3);
            MODE_STATIC:  active = 1'b0;
            default:      active = 1'b0;
        endcase
    end

    // Pulse step from the registered reciprocal product, brightness and chase increment.
    always_comb
    begin
        step_raw = step_prod_reg[RECIP_21_SHIFT +: 12];
        step9    = (step_raw == 12'd0) ? 9'd1 : step_raw[8:0];
        bright   = phase_reg[8] ? ~phase_reg[7:0] : phase_reg[7:0];
        chase_inc = {1'b0, div_rem[PIX_W-1:0]} + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        step_prod_reg <= {17'd0, speed_reg} * {16'd0, RECIP_21};
    end

    // Effect state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            hue_reg     <= '0;
            phase_reg   <= '0;
            blink_reg   <= 1'b1;
            chase_reg   <= '0;
            rand_reg    <= LFSR_SEED;
        end
        else if (mode_wr)
        begin
            elapsed_reg <= '0;
            blink_reg   <= 1'b1;
            phase_reg   <= '0;
            chase_reg   <= '0;
        end
        else
        begin
            if (cmd.tick_inc && (elapsed_reg != ELAPSED_MAX))
                elapsed_reg <= elapsed_reg + 16'd1;
            if (cmd.fire)
            begin
                elapsed_reg <= '0;
                case (mode_reg)
                    MODE_RAINBOW: hue_reg   <= hue_reg + 8'd1;
                    MODE_BLINK:   blink_reg <= ~blink_reg;
                    MODE_PULSE:   phase_reg <= phase_reg + step9;
                    MODE_SPARKLE: rand_reg  <= lfsr_step(rand_reg);
                    default:      ;
                endcase
            end
            if (cmd.div_capture && (mode_reg == MODE_CHASE))
            begin
                if (chase_inc == PIX_W'(0) + {1'b0, count_reg[PIX_W-1:0]} &&
                    ({1'b0, chase_inc} == {1'b0, count_reg}))
                    chase_reg <= '0;
                else if ({1'b0, chase_inc} == {1'b0, count_reg})
                    chase_reg <= '0;
                else
                    chase_reg <= chase_inc[PIX_W-1:0];
            end
        end
    end

    // Rainbow hue accumulator: quotient and remainder of i * 256 / count.
    always_comb
    begin
        acc_sum  = {1'b0, acc_r_reg} + {1'b0, step_b_reg};
        acc_wrap = (acc_sum >= {1'b0, count_reg});
    end

    // Frame working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else if (cmd.fire)
        begin
            pix_reg <= '0;
        end
        else if (cmd.emit)
        begin
            pix_reg <= pix_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            acc_q_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (cmd.emit)
        begin
            if (acc_wrap)
            begin
                acc_q_reg <= acc_q_reg + step_a_reg + 8'd1;
                acc_r_reg <= CNT_W'(acc_sum - {1'b0, count_reg});
            end
            else
            begin
                acc_q_reg <= acc_q_reg + step_a_reg;
                acc_r_reg <= acc_sum[CNT_W-1:0];
            end
        end
        if (cmd.div_capture)
        begin
            step_a_reg <= div_quo[7:0];
            step_b_reg <= div_rem;
            lit_reg    <= div_rem[PIX_W-1:0];
        end
        if (cmd.scale_load)
        begin
            scale_r_reg <= {8'd0, red_reg} * {8'd0, bright};
            scale_g_reg <= {8'd0, green_reg} * {8'd0, bright};
            scale_b_reg <= {8'd0, blue_reg} * {8'd0, bright};
        end
    end

    // Colour of the pixel being issued.
    always_comb
    begin
        eff_color = '{r: red_reg, g: green_reg, b: blue_reg};
        case (mode_reg) inside
            MODE_RAINBOW:
                pix_color = hue_wheel(hue_reg + acc_q_reg);
            MODE_BLINK:
                pix_color = blink_reg ? eff_color : '0;
            MODE_PULSE:
                pix_color = '{r: div255(scale_r_reg), g: div255(scale_g_reg),
                              b: div255(scale_b_reg)};
            MODE_CHASE, MODE_SPARKLE:
                pix_color = (pix_reg == lit_reg) ? eff_color : '0;
            default:
                pix_color = '0;
        endcase
        is_last = (({1'b0, pix_reg} + 1'b1) == count_reg);
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_index_reg <= pix_reg;
            red_reg_o       <= pix_color.r;
            green_reg_o     <= pix_color.g;
            blue_reg_o      <= pix_color.b;
            last_pixel_reg  <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign red         = red_reg_o;
    assign green       = green_reg_o;
    assign blue        = blue_reg_o;
    assign last_pixel  = last_pixel_reg;

    // Status to the controller.
    always_comb
    begin
        st.mode      = mode_reg;
        st.fire_ok   = active && (elapsed_reg >= period);
        st.div_done  = div_done;
        st.slot_free = !out_valid_reg || out_ready;
        st.last      = is_last;
    end

    // A frame always restarts the period counter and the pixel counter.
    a_fire_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fire && !mode_wr) |=> (elapsed_reg == 16'd0) && (pix_reg == '0))
        else $error("frame start did not clear counters");

    // The frame mark sits on the final driven pixel.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_pixel_reg) |->
            (({1'b0, pixel_index_reg} + 1'b1) == count_reg))
        else $error("last pixel mark on wrong position");

    // The output register is never overwritten while its item waits.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("pixel issued into a full output register");

endmodule

### src/ledfx_ctrl.sv
// Controller state machine: tick handling, period check and frame sequencing.
module ledfx_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               tick,
    output logic               in_ready,
    input  ledfx_pkg::status_t st,
    output ledfx_pkg::cmd_t    cmd
);
    import ledfx_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PDIV  = 6'b000010,
        S_CHECK = 6'b000100,
        S_FDIV  = 6'b001000,
        S_SCALE = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && tick)
                begin
                    cmd.tick_inc = 1'b1;
                    if (st.mode == MODE_CHASE)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_PERIOD;
                        state_next    = S_PDIV;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_PDIV:
            begin
                if (st.div_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (st.fire_ok)
                begin
                    cmd.fire = 1'b1;
                    case (st.mode) inside
                        MODE_RAINBOW, MODE_CHASE, MODE_SPARKLE:
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_sel   = DIV_FRAME;
                            state_next    = S_FDIV;
                        end
                        MODE_PULSE:
                            state_next = S_SCALE;
                        default:
                            state_next = S_EMIT;
                    endcase
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FDIV:
            begin
                if (st.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    state_next      = S_EMIT;
                end
            end
            S_SCALE:
            begin
                cmd.scale_load = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.last)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Issuing the final pixel of a frame returns to idle.
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && cmd.emit && st.last) |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after last pixel");

    // A tick that does not fire produces no pixel and goes back to idle.
    a_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && !st.fire_ok) |=> (state_reg == S_IDLE && !cmd.emit))
        else $error("non-firing tick did not return to idle");

    // Divider results are only consumed while waiting for them.
    a_capture_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_capture |-> (state_reg == S_FDIV) && st.div_done)
        else $error("divider result captured outside its wait state");

endmodule

### tb/led_strip_effect_generator_core_tb.sv
// Self-checking testbench of the LED strip effect generator core: ticks, register writes, pixels.
module led_strip_effect_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ledfx_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 64;
    localparam int RANDOM_TICKS   = 240;
    localparam int TIMEOUT_CYCLES = 5_000_000;

    // Register indexes and mode codes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;
    localparam logic [2:0]           MODE_SPARE_LO = 3'd6;
    localparam logic [2:0]           MODE_SPARE_HI = 3'd7;

    // Color wheel geometry and pulse arithmetic.
    localparam int HUE_SEGMENT  = 43;
    localparam int RAMP_GAIN    = 6;
    localparam int HUE_SPAN_INT = 256;
    localparam int PHASE_SPAN   = 512;
    localparam int PHASE_TOP    = 511;
    localparam int PULSE_DIV    = 21;
    localparam int FULL_SCALE   = 255;
    localparam int SPARKLE_DIV  = 8;

    typedef struct packed {
        logic [PIX_W-1:0] pos;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        logic             last;
    } pixel_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  tick      = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      pixel_index;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  last_pixel;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Mirror of the block's registers.
    logic [2:0]  fx_mode  = MODE_STATIC;
    logic [6:0]  fx_count = MAX_STRIP_PIXELS;
    logic [7:0]  fx_red   = '0;
    logic [7:0]  fx_green = '0;
    logic [7:0]  fx_blue  = '0;
    logic [15:0] fx_speed = DEFAULT_SPEED;

    // Mirror of the effect state.
    logic [15:0] ms_elapsed = '0;
    logic [7:0]  hue_base   = '0;
    logic [8:0]  pulse_pos  = '0;
    logic        blink_lit  = 1'b1;
    logic [5:0]  chase_pos  = '0;
    logic [15:0] lfsr       = LFSR_SEED;

    pixel_t      frame_due[$];
    logic        tick_backlog[$];
    reg_write_t  reg_writes[$];
    reg_write_t  next_write;
    pixel_t      want;
    int unsigned ticks_pending  = 0;
    int unsigned writes_pending = 0;
    int unsigned tick_gap       = 0;
    int unsigned stall_left     = 0;
    int unsigned mismatches     = 0;
    logic        idle_free      = 1'b0;

    led_strip_effect_generator_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .tick        (tick),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_pixel  (last_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock generator.
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Milliseconds between frames of the current effect; zero means it never emits.
    function automatic int unsigned frame_period();
        int unsigned per;
        per = 0;
        case (fx_mode)
            MODE_RAINBOW: per = RAINBOW_PERIOD;
            MODE_BLINK:   per = fx_speed;
            MODE_PULSE:   per = PULSE_PERIOD;
            MODE_CHASE:   per = fx_speed / fx_count;
            MODE_SPARKLE: per = fx_speed / SPARKLE_DIV;
            default:      per = 0;
        endcase
        if ((fx_mode == MODE_CHASE || fx_mode == MODE_SPARKLE) && per < MIN_PERIOD)
            per = MIN_PERIOD;
        return per;
    endfunction

    // Advances the effect by one accepted tick and queues the pixels of any frame it fires.
    function automatic void advance_one_ms(input logic t);
        int unsigned per;
        int unsigned lit;
        int unsigned bright;
        int unsigned stride;
        int unsigned hue;
        int unsigned ramp;
        logic [7:0]  pr;
        logic [7:0]  pg;
        logic [7:0]  pb;
        pixel_t      px;
        if (!t)
            return;
        if (ms_elapsed != ELAPSED_MAX)
            ms_elapsed = ms_elapsed + 1'b1;
        per = frame_period();
        if (per == 0 || ms_elapsed < per)
            return;
        ms_elapsed = '0;
        lit    = MAX_STRIP_PIXELS;
        bright = 0;

        // Per-frame state update, ahead of the pixel loop.
        case (fx_mode)
            MODE_RAINBOW: hue_base = hue_base + 1'b1;
            MODE_BLINK:   blink_lit = ~blink_lit;
            MODE_PULSE:
            begin
                stride = fx_speed / PULSE_DIV;
                if (stride == 0)
                    stride = 1;
                pulse_pos = (pulse_pos + stride) % PHASE_SPAN;
                bright = (pulse_pos < HUE_SPAN_INT) ? pulse_pos : PHASE_TOP - pulse_pos;
            end
            MODE_CHASE:
            begin
                lit = chase_pos % fx_count;
                chase_pos = (lit + 1) % fx_count;
            end
            default:
            begin
                lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                lit = lfsr % fx_count;
            end
        endcase

        for (int unsigned i = 0; i < fx_count; i++)
        begin
            pr = '0;
            pg = '0;
            pb = '0;
            case (fx_mode)
                MODE_RAINBOW:
                begin
                    hue  = (hue_base + (i * HUE_SPAN_INT) / fx_count) % HUE_SPAN_INT;
                    ramp = (hue % HUE_SEGMENT) * RAMP_GAIN;
                    case (hue / HUE_SEGMENT)
                        0: begin pr = FULL_SCALE;        pg = ramp;              pb = 0;          end
                        1: begin pr = FULL_SCALE - ramp; pg = FULL_SCALE;        pb = 0;          end
                        2: begin pr = 0;                 pg = FULL_SCALE;        pb = ramp;       end
                        3: begin pr = 0;                 pg = FULL_SCALE - ramp; pb = FULL_SCALE; end
                        4: begin pr = ramp;              pg = 0;                 pb = FULL_SCALE; end
                        default:
                           begin pr = FULL_SCALE;        pg = 0;      pb = FULL_SCALE - ramp; end
                    endcase
                end
                MODE_BLINK:
                begin
                    if (blink_lit)
                    begin
                        pr = fx_red;
                        pg = fx_green;
                        pb = fx_blue;
                    end
                end
                MODE_PULSE:
                begin
                    pr = (fx_red * bright) / FULL_SCALE;
                    pg = (fx_green * bright) / FULL_SCALE;
                    pb = (fx_blue * bright) / FULL_SCALE;
                end
                default:
                begin
                    if (i == lit)
                    begin
                        pr = fx_red;
                        pg = fx_green;
                        pb = fx_blue;
                    end
                end
            endcase
            px.pos  = i[PIX_W-1:0];
            px.r    = pr;
            px.g    = pg;
            px.b    = pb;
            px.last = (i + 1 == fx_count);
            frame_due.push_back(px);
        end
    endfunction

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (idle_free || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic compare_field(input string name, input logic [7:0] exp_val,
                                 input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_val, act_val);
            mismatches++;
        end
    endtask

    task automatic queue_tick(input logic t);
        tick_backlog.push_back(t);
        ticks_pending++;
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        reg_writes.push_back(w);
        writes_pending++;
    endtask

    task automatic flush_writes();
        while (writes_pending != 0)
            @(posedge clk);
    endtask

    // Waits until every item is taken and every pixel is out, then lets the block settle.
    task automatic wait_idle();
        while (writes_pending != 0 || ticks_pending != 0 || frame_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Tick driver: presents queued ticks with random gaps and predicts each accepted item.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_one_ms(tick);
                ticks_pending--;
                tick_gap = pick_gap();
            end
            if ((!in_valid || in_ready) && tick_gap == 0 && tick_backlog.size() != 0)
            begin
                in_valid <= 1'b1;
                tick     <= tick_backlog.pop_front();
            end
            else if (in_valid && in_ready)
            begin
                in_valid <= 1'b0;
            end
            else if (!in_valid && tick_gap != 0)
            begin
                tick_gap--;
            end
        end
    end

    // Register write driver: updates the register mirror as each write is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE:
                    begin
                        fx_mode    = cfg_data[2:0];
                        ms_elapsed = '0;
                        blink_lit  = 1'b1;
                        pulse_pos  = '0;
                        chase_pos  = '0;
                    end
                    REG_COUNT:
                    begin
                        if (cfg_data[6:0] == 0)
                            fx_count = 7'd1;
                        else if (cfg_data[6:0] > MAX_STRIP_PIXELS)
                            fx_count = MAX_STRIP_PIXELS;
                        else
                            fx_count = cfg_data[6:0];
                    end
                    REG_RED:   fx_red   = cfg_data[7:0];
                    REG_GREEN: fx_green = cfg_data[7:0];
                    REG_BLUE:  fx_blue  = cfg_data[7:0];
                    REG_SPEED: fx_speed = (cfg_data == 0) ? DEFAULT_SPEED : cfg_data;
                    default: ;
                endcase
                writes_pending--;
            end
            if ((!cfg_valid || cfg_ready) && reg_writes.size() != 0)
            begin
                next_write = reg_writes.pop_front();
                cfg_valid <= 1'b1;
                cfg_index <= next_write.idx;
                cfg_data  <= next_write.data;
            end
            else if (cfg_valid && cfg_ready)
            begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // Pixel monitor: checks each accepted item against the oldest expected pixel.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frame_due.size() == 0)
                begin
                    $display("%0t ns: unexpected pixel, expected none, actual index %0d", $time,
                             pixel_index);
                    mismatches++;
                end
                else
                begin
                    want = frame_due.pop_front();
                    compare_field("pixel_index", want.pos, pixel_index);
                    compare_field("red", want.r, red);
                    compare_field("green", want.g, green);
                    compare_field("blue", want.b, blue);
                    compare_field("last_pixel", want.last, last_pixel);
                end
                stall_left = pick_gap();
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stimulus: a directed opening, then random register settings each followed by ticks.
    initial
    begin : stimulus
        logic [15:0] word;
        logic [2:0]  next_mode;
        int unsigned roll;
        int unsigned per;
        int unsigned burst;
        int unsigned random_ticks;

        random_ticks = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Static mode after reset: time passes, nothing is emitted, a zero tick does nothing.
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_tick(1'b1);
        wait_idle();

        // Full white on one pixel; zero count and zero speed fall back to 1 and the default.
        queue_write(REG_RED, 16'hFFFF);
        queue_write(REG_GREEN, 16'hFFFF);
        queue_write(REG_BLUE, 16'hFFFF);
        queue_write(REG_COUNT, 16'h0000);
        queue_write(REG_SPEED, 16'h0000);
        queue_write(REG_MODE, {13'h1FFF, MODE_BLINK});
        flush_writes();
        repeat (3) queue_tick(1'b1);
        wait_idle();

        // A shorter speed takes effect on the time already counted.
        queue_write(REG_SPEED, 16'd1);
        flush_writes();
        queue_tick(1'b1);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_tick(1'b1);
        wait_idle();

        // Oversized count clamps to the full strip; undecoded indexes change nothing.
        queue_write(REG_COUNT, 16'hFFC8);
        queue_write(REG_SPARE_LO, 16'hFFFF);
        queue_write(REG_SPARE_HI, 16'h0000);
        queue_write(REG_BLUE, 16'h0000);
        flush_writes();
        repeat (2) queue_tick(1'b1);
        wait_idle();

        // Undecoded modes behave as static.
        queue_write(REG_MODE, {13'h0000, MODE_SPARE_LO});
        flush_writes();
        repeat (2) queue_tick(1'b1);
        wait_idle();
        queue_write(REG_MODE, {13'h1FFF, MODE_SPARE_HI});
        flush_writes();
        queue_tick(1'b1);
        wait_idle();

        // Random settings, each followed by enough ticks to see a few frames.
        while (random_ticks < RANDOM_TICKS)
        begin
            idle_free = ($urandom_range(0, 4) == 0);
            next_mode = fx_mode;
            if ($urandom_range(0, 4) != 0)
            begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       next_mode = MODE_STATIC;
                        1:       next_mode = MODE_SPARE_LO;
                        default: next_mode = MODE_SPARE_HI;
                    endcase
                end
                else if (roll <= 4)
                    next_mode = MODE_RAINBOW;
                else if (roll <= 8)
                    next_mode = MODE_BLINK;
                else if (roll <= 12)
                    next_mode = MODE_PULSE;
                else if (roll <= 16)
                    next_mode = MODE_CHASE;
                else
                    next_mode = MODE_SPARKLE;
                word = $urandom;
                word[2:0] = next_mode;
                queue_write(REG_MODE, word);
            end
            if ($urandom_range(0, 4) < 3)
            begin
                word = $urandom;
                roll = $urandom_range(0, 19);
                if (roll < 14)
                    word[6:0] = $urandom_range(1, 8);
                else if (roll < 17)
                    word[6:0] = $urandom_range(9, MAX_STRIP_PIXELS);
                else if (roll == 17)
                    word[6:0] = '0;
                else if (roll == 18)
                    word[6:0] = MAX_STRIP_PIXELS;
                queue_write(REG_COUNT, word);
            end
            for (int c = 0; c < 3; c++)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    word = $urandom;
                    roll = $urandom_range(0, 3);
                    if (roll == 0)
                        word[7:0] = 8'h00;
                    else if (roll == 1)
                        word[7:0] = 8'hFF;
                    queue_write((c == 0) ? REG_RED : ((c == 1) ? REG_GREEN : REG_BLUE), word);
                end
            end
            if ($urandom_range(0, 4) < 3)
            begin
                if (next_mode == MODE_BLINK && $urandom_range(0, 4) != 0)
                    word = $urandom_range(1, 6);
                else
                begin
                    case ($urandom_range(0, 5))
                        0:       word = 16'h0000;
                        1:       word = 16'hFFFF;
                        2:       word = 16'd1;
                        3:       word = $urandom;
                        default: word = $urandom_range(2, 1200);
                    endcase
                end
                queue_write(REG_SPEED, word);
            end
            flush_writes();

            // Tick count scales with the frame period so most phases fire a few frames.
            per = frame_period();
            if (per == 0)
                burst = $urandom_range(1, 6);
            else
                burst = ((per > 60) ? 60 : per) * $urandom_range(1, 3) + $urandom_range(0, 3);
            random_ticks += burst;
            repeat (burst) queue_tick($urandom_range(0, 19) != 0);
            wait_idle();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("status: fail");
        $finish;
    end

endmodule

### sim.f
src/ledfx_pkg.sv
src/ledfx_div.sv
src/ledfx_dp.sv
src/ledfx_ctrl.sv
src/led_strip_effect_generator_core.sv
tb/led_strip_effect_generator_core_tb.sv
